// ===== hw/rtl/lfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lfr_pkg;

    localparam int DEF_MAX_GROUPS = 64;
    localparam int LABEL_W        = 32;
    localparam int GROUP_W        = 7;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input transfer, restart the scan
        logic read;     // issue table read at scan index
        logic step;     // advance scan index
        logic hit;      // record match at scan index
        logic finish;   // form result, update table and count
    } lfr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic used_zero;   // table empty
        logic match;       // table read data equals held label
        logic last_entry;  // scan index is the last valid entry
        logic out_free;    // output register can take a result this cycle
    } lfr_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lfr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lfr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lfr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire lfr_pkg::lfr_status_t status,
    output lfr_pkg::lfr_cmd_t         cmd
);

    import lfr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.used_zero ? ST_DONE : ST_RD;
                end
            end
            ST_RD:
            begin
                cmd.read   = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                priority if (status.match)
                begin
                    cmd.hit    = 1'b1;
                    state_next = ST_DONE;
                end
                else if (status.last_entry)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lfr_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lfr_dp #(
    parameter int MAX_GROUPS = lfr_pkg::DEF_MAX_GROUPS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [lfr_pkg::LABEL_W-1:0] in_label,
    input  wire logic                        in_last,
    input  wire lfr_pkg::lfr_cmd_t           cmd,
    output lfr_pkg::lfr_status_t             status,
    input  wire logic                        out_ready,
    output logic                             out_valid,
    output logic [lfr_pkg::GROUP_W-1:0]      out_group,
    output logic                             out_overflow,
    output logic                             out_last
);

    import lfr_pkg::*;

    localparam int AW = $clog2(MAX_GROUPS);
    localparam int CW = $clog2(MAX_GROUPS + 1);

    logic [LABEL_W-1:0] label_reg;
    logic               last_reg;
    logic [CW-1:0]      used_reg;
    logic [CW-1:0]      used_next;
    logic [CW-1:0]      idx_reg;
    logic               found_reg;
    logic [CW-1:0]      grp_reg;

    logic               out_valid_reg;
    logic [GROUP_W-1:0] out_group_reg;
    logic               out_overflow_reg;
    logic               out_last_reg;

    logic [LABEL_W-1:0] rd_data;
    logic               room;
    logic               wr_en;
    logic [CW-1:0]      res_grp;
    logic               res_ovf;

    lfr_ram #(
        .WIDTH(LABEL_W),
        .DEPTH(MAX_GROUPS)
    ) u_table (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(used_reg[AW-1:0]),
        .wr_data(label_reg),
        .rd_en  (cmd.read),
        .rd_addr(idx_reg[AW-1:0]),
        .rd_data(rd_data)
    );

    assign room = used_reg < CW'(MAX_GROUPS);

    // result of the current item, used on finish
    always_comb
    begin
        wr_en     = 1'b0;
        res_grp   = '0;
        res_ovf   = 1'b0;
        used_next = used_reg;
        priority if (found_reg)
        begin
            res_grp = grp_reg;
        end
        else if (room)
        begin
            wr_en     = cmd.finish;
            res_grp   = used_reg + CW'(1);
            used_next = used_reg + CW'(1);
        end
        else
        begin
            res_ovf = 1'b1;
        end
    end

    assign status.used_zero  = (used_reg == '0);
    assign status.match      = (rd_data == label_reg);
    assign status.last_entry = ((idx_reg + CW'(1)) == used_reg);
    assign status.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            label_reg <= in_label;
            last_reg  <= in_last;
        end
        if (cmd.hit)
        begin
            grp_reg <= idx_reg + CW'(1);
        end
        if (cmd.finish)
        begin
            out_group_reg    <= GROUP_W'(res_grp);
            out_overflow_reg <= res_ovf;
            out_last_reg     <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.hit)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                used_reg      <= last_reg ? '0 : used_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_group    = out_group_reg;
    assign out_overflow = out_overflow_reg;
    assign out_last     = out_last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/label_first_occurrence_renumber.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Renumbers a stream of 32-bit cluster labels by order of first appearance
// within a vector: the first distinct label gets group 1, the next new one
// group 2, and so on. tlast on the input marks the last label of a vector;
// the table of seen labels is emptied after it, and tlast is copied to the
// result. A new label arriving with MAX_GROUPS groups in use gives group 0
// with the overflow bit set and is not stored. The table lives in a RAM and
// is scanned entry by entry, each entry being read and then compared, so
// the time an item takes grows with the index of the entry it matches or,
// for a new label, with the number of groups in use; one item is in flight
// at a time, and the input is ready again while a finished result waits in the output register.
module label_first_occurrence_renumber #(
    parameter int MAX_GROUPS = lfr_pkg::DEF_MAX_GROUPS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [lfr_pkg::LABEL_W-1:0] s_tdata,  // [31:0] label
    input  wire logic                        s_tlast,  // last_item
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [7:0]                       m_tdata,  // [6:0] group_number, [7] overflow
    output logic                             m_tlast   // last_result
);

    import lfr_pkg::*;

    lfr_cmd_t           cmd;
    lfr_status_t        status;
    logic [GROUP_W-1:0] group_number;
    logic               overflow;

    lfr_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    lfr_dp #(
        .MAX_GROUPS(MAX_GROUPS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_label    (s_tdata),
        .in_last     (s_tlast),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_group   (group_number),
        .out_overflow(overflow),
        .out_last    (m_tlast)
    );

    assign m_tdata = {overflow, group_number};

endmodule

`default_nettype wire
